### hdl/i2cdws_pkg.sv
// Shared types and constants for the I2C display write sequencer.
package i2cdws_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESTOP,
    ST_START,
    ST_BITS,
    ST_ACK,
    ST_STOP
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_ADDR,
    PH_CTRL,
    PH_DATA
  } byte_phase_t;

  typedef logic [1:0] cell_kind_t;

  localparam cell_kind_t CELL_START = 2'd0;
  localparam cell_kind_t CELL_BIT   = 2'd1;
  localparam cell_kind_t CELL_ACK   = 2'd2;
  localparam cell_kind_t CELL_STOP  = 2'd3;

  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  localparam logic [7:0]  ADDR_RESET = 8'h78;
  localparam logic [15:0] HALF_RESET = 16'd400;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD    = 8'd1;

  localparam logic [2:0] BIT_LAST = 3'd7;

endpackage

### hdl/i2c_display_write_sequencer_top.sv
// Top level of the I2C display write sequencer: item in, bus cells out.
//
// Each accepted item becomes a run of bus cells (start, eight data bits
// per byte MSB first, acknowledge clock, stop). A command item gives 29
// cells, or 30 when it must first close an open data stream; a data item
// gives 9, 10, 28 or 29. Cells are paced by the half-period timer: each
// cell is offered two half periods after the item was taken or the previous
// cell was issued, and a stalled output holds the next cell back. The byte
// in flight leaves a shift register one bit per cell. A new item is taken
// once the previous item's last cell sits in the output register.
// Configuration writes are always taken; an unknown index is ignored.
module i2c_display_write_sequencer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_end_of_stream,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_cell_kind,
  output logic                               out_sda_level,
  output logic                               out_last_cell,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cdws_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cdws_pkg::CFG_DATA_W-1:0]  cfg_data
);

  i2cdws_pkg::seq_state_t  state_r, state_nxt;
  i2cdws_pkg::byte_phase_t phase_r, phase_nxt;

  logic [7:0]  dev_addr_r;
  logic [15:0] half_ticks_r;
  logic        stream_open_r, stream_open_nxt;
  logic        func_r, func_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        eos_r, eos_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        half_r, half_nxt;

  logic                   out_valid_r, out_valid_nxt;
  i2cdws_pkg::cell_kind_t out_kind_r, out_kind_nxt;
  logic                   out_sda_r, out_sda_nxt;
  logic                   out_last_r, out_last_nxt;

  logic in_fire;
  logic pace_done;
  logic cell_fire;

  assign in_ready      = (state_r == i2cdws_pkg::ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_cell_kind = out_kind_r;
  assign out_sda_level = out_sda_r;
  assign out_last_cell = out_last_r;

  assign pace_done = half_r && (tick_r == 16'd0);
  assign cell_fire = (state_r != i2cdws_pkg::ST_IDLE) && pace_done &&
                     (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= i2cdws_pkg::ADDR_RESET;
      half_ticks_r <= i2cdws_pkg::HALF_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == i2cdws_pkg::REG_DEVICE_ADDRESS) begin
        dev_addr_r <= cfg_data[7:0];
      end else if (cfg_index == i2cdws_pkg::REG_HALF_PERIOD) begin
        half_ticks_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= i2cdws_pkg::ST_IDLE;
      phase_r       <= i2cdws_pkg::PH_ADDR;
      stream_open_r <= 1'b0;
      out_valid_r   <= 1'b0;
      bit_cnt_r     <= 3'd0;
      tick_r        <= 16'd0;
      half_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      stream_open_r <= stream_open_nxt;
      out_valid_r   <= out_valid_nxt;
      bit_cnt_r     <= bit_cnt_nxt;
      tick_r        <= tick_nxt;
      half_r        <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    byte_r     <= byte_nxt;
    eos_r      <= eos_nxt;
    shift_r    <= shift_nxt;
    out_kind_r <= out_kind_nxt;
    out_sda_r  <= out_sda_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    stream_open_nxt = stream_open_r;
    func_nxt        = func_r;
    byte_nxt        = byte_r;
    eos_nxt         = eos_r;
    shift_nxt       = shift_r;
    bit_cnt_nxt     = bit_cnt_r;
    tick_nxt        = tick_r;
    half_nxt        = half_r;
    out_valid_nxt   = out_valid_r;
    out_kind_nxt    = out_kind_r;
    out_sda_nxt     = out_sda_r;
    out_last_nxt    = out_last_r;

    // advance the half-period timer
    if (state_r != i2cdws_pkg::ST_IDLE && !pace_done) begin
      if (tick_r == 16'd0) begin
        half_nxt = 1'b1;
        tick_nxt = half_ticks_r - 16'd1;
      end else begin
        tick_nxt = tick_r - 16'd1;
      end
    end

    // drop the taken cell
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire || cell_fire) begin
      tick_nxt = half_ticks_r - 16'd1;
      half_nxt = 1'b0;
    end

    if (in_fire) begin
      func_nxt    = in_func;
      byte_nxt    = in_data_byte;
      eos_nxt     = in_end_of_stream;
      bit_cnt_nxt = 3'd0;
      if (!in_func) begin
        state_nxt = stream_open_r ? i2cdws_pkg::ST_PRESTOP : i2cdws_pkg::ST_START;
      end else if (stream_open_r) begin
        shift_nxt = in_data_byte;
        phase_nxt = i2cdws_pkg::PH_DATA;
        state_nxt = i2cdws_pkg::ST_BITS;
      end else begin
        state_nxt = i2cdws_pkg::ST_START;
      end
    end

    if (cell_fire) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      unique case (state_r)
        i2cdws_pkg::ST_PRESTOP: begin
          out_kind_nxt    = i2cdws_pkg::CELL_STOP;
          out_sda_nxt     = 1'b1;
          stream_open_nxt = 1'b0;
          state_nxt       = i2cdws_pkg::ST_START;
        end
        i2cdws_pkg::ST_START: begin
          out_kind_nxt = i2cdws_pkg::CELL_START;
          out_sda_nxt  = 1'b0;
          shift_nxt    = dev_addr_r;
          phase_nxt    = i2cdws_pkg::PH_ADDR;
          bit_cnt_nxt  = 3'd0;
          state_nxt    = i2cdws_pkg::ST_BITS;
        end
        i2cdws_pkg::ST_BITS: begin
          out_kind_nxt = i2cdws_pkg::CELL_BIT;
          out_sda_nxt  = shift_r[7];
          shift_nxt    = {shift_r[6:0], 1'b0};
          bit_cnt_nxt  = bit_cnt_r + 3'd1;
          if (bit_cnt_r == i2cdws_pkg::BIT_LAST) begin
            state_nxt = i2cdws_pkg::ST_ACK;
          end
        end
        i2cdws_pkg::ST_ACK: begin
          out_kind_nxt = i2cdws_pkg::CELL_ACK;
          out_sda_nxt  = 1'b1;
          bit_cnt_nxt  = 3'd0;
          unique case (phase_r)
            i2cdws_pkg::PH_ADDR: begin
              shift_nxt = func_r ? i2cdws_pkg::CTRL_DATA : i2cdws_pkg::CTRL_COMMAND;
              phase_nxt = i2cdws_pkg::PH_CTRL;
              state_nxt = i2cdws_pkg::ST_BITS;
            end
            i2cdws_pkg::PH_CTRL: begin
              shift_nxt = byte_r;
              phase_nxt = i2cdws_pkg::PH_DATA;
              state_nxt = i2cdws_pkg::ST_BITS;
            end
            default: begin
              if (!func_r || eos_r) begin
                state_nxt = i2cdws_pkg::ST_STOP;
              end else begin
                out_last_nxt    = 1'b1;
                stream_open_nxt = 1'b1;
                state_nxt       = i2cdws_pkg::ST_IDLE;
              end
            end
          endcase
        end
        i2cdws_pkg::ST_STOP: begin
          out_kind_nxt    = i2cdws_pkg::CELL_STOP;
          out_sda_nxt     = 1'b1;
          out_last_nxt    = 1'b1;
          stream_open_nxt = 1'b0;
          state_nxt       = i2cdws_pkg::ST_IDLE;
        end
        default: begin
          state_nxt = i2cdws_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/tb_i2c_display_write_sequencer_top.sv
// Self-checking bench for the I2C display write sequencer: predicts bus cells per item.
module tb_i2c_display_write_sequencer_top;

  localparam logic FUNC_COMMAND = 1'b0;
  localparam logic FUNC_DATA    = 1'b1;
  localparam logic [i2cdws_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;
  localparam int RANDOM_ITEMS = 100;
  localparam int SEGMENT_ITEMS = 25;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_PCT = 14;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    i2cdws_pkg::cell_kind_t kind;
    logic                   sda;
    logic                   last_cell;
  } bus_cell_t;

  class bus_cell_scoreboard;
    bus_cell_t        cells_due[$];
    logic [7:0]       dev_addr;
    bit               stream_open;
    int               errors;

    function new();
      dev_addr    = i2cdws_pkg::ADDR_RESET;
      stream_open = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [i2cdws_pkg::CFG_INDEX_W-1:0] idx,
                            logic [i2cdws_pkg::CFG_DATA_W-1:0] value);
      if (idx == i2cdws_pkg::REG_DEVICE_ADDRESS) begin
        dev_addr = value[7:0];
      end
    endfunction

    function void add_cell(i2cdws_pkg::cell_kind_t kind, logic sda);
      bus_cell_t c;
      c.kind      = kind;
      c.sda       = sda;
      c.last_cell = 1'b0;
      cells_due.push_back(c);
    endfunction

    function void add_byte(logic [7:0] value);
      for (int k = 7; k >= 0; k--) begin
        add_cell(i2cdws_pkg::CELL_BIT, value[k]);
      end
      add_cell(i2cdws_pkg::CELL_ACK, 1'b1);
    endfunction

    function void note_item(logic func, logic [7:0] data_byte, logic end_of_stream);
      if (func == FUNC_COMMAND) begin
        if (stream_open) begin
          add_cell(i2cdws_pkg::CELL_STOP, 1'b1);
        end
        add_cell(i2cdws_pkg::CELL_START, 1'b0);
        add_byte(dev_addr);
        add_byte(i2cdws_pkg::CTRL_COMMAND);
        add_byte(data_byte);
        add_cell(i2cdws_pkg::CELL_STOP, 1'b1);
        stream_open = 1'b0;
      end else begin
        if (!stream_open) begin
          add_cell(i2cdws_pkg::CELL_START, 1'b0);
          add_byte(dev_addr);
          add_byte(i2cdws_pkg::CTRL_DATA);
          stream_open = 1'b1;
        end
        add_byte(data_byte);
        if (end_of_stream) begin
          add_cell(i2cdws_pkg::CELL_STOP, 1'b1);
          stream_open = 1'b0;
        end
      end
      cells_due[cells_due.size()-1].last_cell = 1'b1;
    endfunction

    function void check_cell(logic [1:0] kind, logic sda, logic last_cell);
      bus_cell_t want;
      if (cells_due.size() == 0) begin
        $error("unexpected cell: cell_kind=%0d sda_level=%0b last_cell=%0b", kind, sda,
               last_cell);
        errors++;
        return;
      end
      want = cells_due.pop_front();
      if (kind !== want.kind) begin
        $error("cell_kind mismatch: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (sda !== want.sda) begin
        $error("sda_level mismatch: expected %0b, actual %0b", want.sda, sda);
        errors++;
      end
      if (last_cell !== want.last_cell) begin
        $error("last_cell mismatch: expected %0b, actual %0b", want.last_cell, last_cell);
        errors++;
      end
    endfunction

    function int pending();
      return cells_due.size();
    endfunction
  endclass

  logic                                   clk;
  logic                                   rst_n;
  logic                                   in_valid;
  logic                                   in_ready;
  logic                                   in_func;
  logic [7:0]                             in_data_byte;
  logic                                   in_end_of_stream;
  logic                                   out_valid;
  logic                                   out_ready;
  logic [1:0]                             out_cell_kind;
  logic                                   out_sda_level;
  logic                                   out_last_cell;
  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [i2cdws_pkg::CFG_INDEX_W-1:0]     cfg_index;
  logic [i2cdws_pkg::CFG_DATA_W-1:0]      cfg_data;

  bus_cell_scoreboard cell_board;
  bit calm;
  int hold_asks = 0;
  int holds_done = 0;
  int items_sent;
  int quiet_cycles = 0;

  i2c_display_write_sequencer_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_kind    (out_cell_kind),
    .out_sda_level    (out_sda_level),
    .out_last_cell    (out_last_cell),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, or a long hold when asked
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      cell_board.check_cell(out_cell_kind, out_sda_level, out_last_cell);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(logic func, logic [7:0] data_byte, logic end_of_stream);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= func;
    in_data_byte     <= data_byte;
    in_end_of_stream <= end_of_stream;
    do @(posedge clk); while (!in_ready);
    cell_board.note_item(func, data_byte, end_of_stream);
    items_sent++;
  endtask

  task automatic write_reg(logic [i2cdws_pkg::CFG_INDEX_W-1:0] idx,
                           logic [i2cdws_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cell_board.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and hold until every predicted cell has arrived
  task automatic drain;
    in_valid <= 1'b0;
    while (cell_board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed;
    send_item(FUNC_COMMAND, 8'hAE, 1'b0);
    send_item(FUNC_DATA, 8'hFF, 1'b1);
    drain();
    write_reg(i2cdws_pkg::REG_HALF_PERIOD, 16'hFFFF);
    write_reg(i2cdws_pkg::REG_HALF_PERIOD, 16'd1);
    write_reg(i2cdws_pkg::REG_DEVICE_ADDRESS, 16'h0000);
    send_item(FUNC_COMMAND, 8'h00, 1'b1);
    send_item(FUNC_COMMAND, 8'hFF, 1'b0);
    send_item(FUNC_DATA, 8'h00, 1'b0);
    send_item(FUNC_DATA, 8'hFF, 1'b0);
    send_item(FUNC_DATA, 8'h5A, 1'b1);
    send_item(FUNC_DATA, 8'hA5, 1'b0);
    send_item(FUNC_COMMAND, 8'h81, 1'b0);
    send_item(FUNC_DATA, 8'h01, 1'b0);
    send_item(FUNC_DATA, 8'h80, 1'b0);
    send_item(FUNC_COMMAND, 8'h7F, 1'b1);
    drain();
    write_reg(i2cdws_pkg::REG_DEVICE_ADDRESS, 16'hA5FF);
    write_reg(i2cdws_pkg::REG_HALF_PERIOD, 16'd2);
    write_reg(REG_UNUSED, 16'h0012);
    send_item(FUNC_DATA, 8'h3C, 1'b1);
    send_item(FUNC_COMMAND, 8'hC3, 1'b0);
    send_item(FUNC_DATA, 8'h96, 1'b0);
    drain();
  endtask

  task automatic run_random;
    int seg;
    int seg_start;
    int pick;
    int len;
    for (seg = 0; seg * SEGMENT_ITEMS < RANDOM_ITEMS; seg++) begin
      drain();
      write_reg(i2cdws_pkg::REG_DEVICE_ADDRESS, 16'($urandom_range(0, 255)));
      write_reg(i2cdws_pkg::REG_HALF_PERIOD, 16'($urandom_range(1, 6)));
      calm = (seg == 1);
      if (seg == 2) begin
        hold_asks++;
      end
      seg_start = items_sent;
      while (items_sent - seg_start < SEGMENT_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          len = $urandom_range(1, 5);
          for (int k = 0; k < len; k++) begin
            send_item(FUNC_DATA, 8'($urandom_range(0, 255)), k == len - 1);
          end
          if ($urandom_range(99) < 30) begin
            send_item(FUNC_COMMAND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
        end else if (pick < 85) begin
          send_item(FUNC_COMMAND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          send_item(FUNC_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    cell_board       = new();
    calm             = 1'b0;
    items_sent       = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_func          <= FUNC_COMMAND;
    in_data_byte     <= 8'h00;
    in_end_of_stream <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= i2cdws_pkg::REG_DEVICE_ADDRESS;
    cfg_data         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    drain();
    if (cell_board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### i2c_display_write_sequencer_top.f
hdl/i2cdws_pkg.sv
hdl/i2c_display_write_sequencer_top.sv
bench/tb_i2c_display_write_sequencer_top.sv
